### rtl/hswr_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the humidity sensor wire reader.
// Used by the controller, the datapath and the top level.
package hswr_pkg;

  // Transaction shape
  localparam int TRANSITIONS      = 85;
  localparam int SKIP_TRANSITIONS = 3;
  localparam int NUM_BYTES        = 5;
  localparam int BIT_LIMIT        = 40;

  // Field widths
  localparam int SETTLE_W  = 18;
  localparam int REQUEST_W = 16;
  localparam int RELEASE_W = 8;
  localparam int THRESH_W  = 8;
  localparam int TIMER_W   = 18;
  localparam int DUR_W     = 8;
  localparam int TIDX_W    = 7;
  localparam int BIDX_W    = 6;
  localparam int BYTE_W    = 8;
  localparam int BSEL_W    = 3;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 18;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SETTLE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_REQUEST   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_RELEASE   = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd3;

  // Configuration reset values
  localparam logic [SETTLE_W-1:0]  SETTLE_RESET    = 18'd250000;
  localparam logic [REQUEST_W-1:0] REQUEST_RESET   = 16'd20000;
  localparam logic [RELEASE_W-1:0] RELEASE_RESET   = 8'd40;
  localparam logic [THRESH_W-1:0]  THRESHOLD_RESET = 8'd40;

  // Transaction phase, one-hot
  typedef enum logic [5:0] {
    PH_IDLE    = 6'b000001,
    PH_SETTLE  = 6'b000010,
    PH_REQUEST = 6'b000100,
    PH_RELEASE = 6'b001000,
    PH_FIRST   = 6'b010000,
    PH_MEASURE = 6'b100000
  } phase_t;

  // Controller to datapath
  typedef struct packed {
    logic   accept;
    logic   start;
    phase_t phase;
    logic   busy;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic timer_hit;
    logic transition;
    logic last_transition;
  } status_t;

endpackage

### rtl/hswr_in_if.sv
`timescale 1ns / 1ps
// Input channel: one microsecond tick with start request and wire sample.
// Standalone interface; no package dependency.
interface hswr_in_if;
  logic valid;
  logic ready;
  logic start_req;
  logic choose_temperature;
  logic wire_level;

  modport source(output valid, output start_req, output choose_temperature,
                 output wire_level, input ready);
  modport sink(input valid, input start_req, input choose_temperature,
               input wire_level, output ready);
endinterface

### rtl/hswr_out_if.sv
`timescale 1ns / 1ps
// Output channel: per-tick wire drive, status and reading.
// Standalone interface; no package dependency.
interface hswr_out_if;
  logic       valid;
  logic       ready;
  logic       drive_enable;
  logic       drive_level;
  logic       busy_res;
  logic       done_res;
  logic       checksum_ok;
  logic [7:0] reading;

  modport source(output valid, output drive_enable, output drive_level,
                 output busy_res, output done_res, output checksum_ok,
                 output reading, input ready);
  modport sink(input valid, input drive_enable, input drive_level,
               input busy_res, input done_res, input checksum_ok,
               input reading, output ready);
endinterface

### rtl/hswr_ctrl.sv
`timescale 1ns / 1ps
// Controller: transaction phase state machine and channel handshake.
// Depends on hswr_pkg for the phase, command and status types.
module hswr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  logic            start_req,
  output logic            out_valid,
  input  logic            out_ready,
  output hswr_pkg::cmd_t  cmd,
  input  hswr_pkg::status_t status
);
  import hswr_pkg::*;

  phase_t phase;
  phase_t phase_next;
  phase_t cur_phase;
  logic   accept;

  // A new tick is taken whenever the result register is free or draining.
  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  // A start request restarts the read in the settle phase on the same tick.
  assign cur_phase = start_req ? PH_SETTLE : phase;

  // Phase sequencing.
  always_comb begin
    phase_next = cur_phase;
    unique case (cur_phase)
      PH_IDLE:    phase_next = PH_IDLE;
      PH_SETTLE:  if (status.timer_hit) phase_next = PH_REQUEST;
      PH_REQUEST: if (status.timer_hit) phase_next = PH_RELEASE;
      PH_RELEASE: if (status.timer_hit) phase_next = PH_FIRST;
      PH_FIRST:   phase_next = PH_MEASURE;
      PH_MEASURE: if (status.transition && status.last_transition) phase_next = PH_IDLE;
      default:    phase_next = PH_IDLE;
    endcase
  end

  // Commands to the datapath.
  always_comb begin
    cmd.accept = accept;
    cmd.start  = start_req;
    cmd.phase  = cur_phase;
    cmd.busy   = (phase_next != PH_IDLE);
  end

  // Phase register advances once per accepted tick.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
    end else if (accept) begin
      phase <= phase_next;
    end
  end

  // Result valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

endmodule

### rtl/hswr_datapath.sv
`timescale 1ns / 1ps
// Datapath: configuration registers, phase timer, pulse timing, bit
// assembly, checksum and result register. Depends on hswr_pkg.
module hswr_datapath (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_we,
  input  logic [hswr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hswr_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                            choose_temperature,
  input  logic                            wire_level,
  input  hswr_pkg::cmd_t                  cmd,
  output hswr_pkg::status_t               status,
  output logic                            drive_enable,
  output logic                            drive_level,
  output logic                            busy_res,
  output logic                            done_res,
  output logic                            checksum_ok,
  output logic [hswr_pkg::BYTE_W-1:0]     reading
);
  import hswr_pkg::*;

  // Configuration
  logic [SETTLE_W-1:0]  settle_high_us;
  logic [REQUEST_W-1:0] request_low_us;
  logic [RELEASE_W-1:0] release_high_us;
  logic [THRESH_W-1:0]  one_threshold_us;

  // Transaction state
  logic [TIMER_W-1:0] phase_timer, phase_timer_next;
  logic [DUR_W-1:0]   level_duration, level_duration_next;
  logic               previous_level, previous_level_next;
  logic [TIDX_W-1:0]  transition_index, transition_index_next;
  logic [BIDX_W-1:0]  bit_index, bit_index_next;
  logic [BYTE_W-1:0]  received_bytes [NUM_BYTES];
  logic [BYTE_W-1:0]  received_bytes_next [NUM_BYTES];
  logic               want_temperature, want_temperature_next;

  // Per-tick results
  logic               en_now, lvl_now, done_now, ok_now;
  logic [BYTE_W-1:0]  reading_now;

  // Intermediate values
  logic [TIMER_W-1:0] timer_cur, timer_inc, timer_limit;
  logic [TIDX_W-1:0]  tidx_cur, tidx_inc;
  logic [DUR_W-1:0]   dur_cur;
  logic               prev_cur;
  logic [BIDX_W-1:0]  bidx_cur;
  logic               take_bit;
  logic [BSEL_W-1:0]  byte_sel;
  logic [BYTE_W+1:0]  sum_full;
  logic [BYTE_W-1:0]  sum_low;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      settle_high_us   <= SETTLE_RESET;
      request_low_us   <= REQUEST_RESET;
      release_high_us  <= RELEASE_RESET;
      one_threshold_us <= THRESHOLD_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_SETTLE:    settle_high_us   <= cfg_data[SETTLE_W-1:0];
        CFG_REQUEST:   request_low_us   <= cfg_data[REQUEST_W-1:0];
        CFG_RELEASE:   release_high_us  <= cfg_data[RELEASE_W-1:0];
        CFG_THRESHOLD: one_threshold_us <= cfg_data[THRESH_W-1:0];
        default:       ;
      endcase
    end
  end

  // State as seen by this tick: a start clears the transaction first.
  assign timer_cur = cmd.start ? '0 : phase_timer;
  assign tidx_cur  = cmd.start ? '0 : transition_index;
  assign dur_cur   = cmd.start ? '0 : level_duration;
  assign prev_cur  = cmd.start ? 1'b0 : previous_level;
  assign bidx_cur  = cmd.start ? '0 : bit_index;

  // Drive phase timer and its limit.
  assign timer_inc = timer_cur + TIMER_W'(1);
  always_comb begin
    timer_limit = settle_high_us;
    unique case (cmd.phase)
      PH_REQUEST: timer_limit = TIMER_W'(request_low_us);
      PH_RELEASE: timer_limit = TIMER_W'(release_high_us);
      default:    timer_limit = settle_high_us;
    endcase
  end

  // Transition detection and counting.
  assign tidx_inc = tidx_cur + TIDX_W'(1);
  assign status.timer_hit       = (timer_inc >= timer_limit);
  assign status.transition      = (wire_level != prev_cur);
  assign status.last_transition = (tidx_inc >= TIDX_W'(TRANSITIONS));

  // A falling edge after the preamble closes a data bit.
  assign take_bit = (cmd.phase == PH_MEASURE) && status.transition && prev_cur &&
                    (tidx_cur >= TIDX_W'(SKIP_TRANSITIONS)) &&
                    (bidx_cur < BIDX_W'(BIT_LIMIT));
  assign byte_sel = bidx_cur[BIDX_W-1:3];

  // Byte assembly, MSB first.
  always_comb begin
    for (int i = 0; i < NUM_BYTES; i++) begin
      received_bytes_next[i] = cmd.start ? '0 : received_bytes[i];
      if (take_bit && (byte_sel == BSEL_W'(i))) begin
        received_bytes_next[i] = {received_bytes[i][BYTE_W-2:0],
                                  (level_duration >= one_threshold_us)};
      end
    end
  end

  // Checksum over the first four bytes, low eight bits.
  assign sum_full = {2'b00, received_bytes_next[0]} + {2'b00, received_bytes_next[1]} +
                    {2'b00, received_bytes_next[2]} + {2'b00, received_bytes_next[3]};
  assign sum_low  = sum_full[BYTE_W-1:0];

  // Per-phase state update and tick results.
  always_comb begin
    phase_timer_next      = timer_cur;
    level_duration_next   = dur_cur;
    previous_level_next   = prev_cur;
    transition_index_next = tidx_cur;
    bit_index_next        = bidx_cur;
    want_temperature_next = cmd.start ? choose_temperature : want_temperature;
    en_now      = 1'b0;
    lvl_now     = 1'b0;
    done_now    = 1'b0;
    ok_now      = 1'b0;
    reading_now = '0;
    unique case (cmd.phase)
      PH_IDLE: begin
      end
      PH_SETTLE, PH_RELEASE: begin
        en_now  = 1'b1;
        lvl_now = 1'b1;
        phase_timer_next = status.timer_hit ? '0 : timer_inc;
      end
      PH_REQUEST: begin
        en_now = 1'b1;
        phase_timer_next = status.timer_hit ? '0 : timer_inc;
      end
      PH_FIRST: begin
        previous_level_next = wire_level;
        level_duration_next = '0;
      end
      PH_MEASURE: begin
        if (!status.transition) begin
          if (dur_cur != '1) level_duration_next = dur_cur + DUR_W'(1);
        end else begin
          if (take_bit) bit_index_next = bidx_cur + BIDX_W'(1);
          previous_level_next   = wire_level;
          level_duration_next   = '0;
          transition_index_next = tidx_inc;
          if (status.last_transition) begin
            done_now = 1'b1;
            ok_now   = (sum_low == received_bytes_next[4]);
            if (sum_low == received_bytes_next[4]) begin
              reading_now = want_temperature ? received_bytes_next[2]
                                             : received_bytes_next[0];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // Transaction state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_timer      <= '0;
      level_duration   <= '0;
      previous_level   <= 1'b0;
      transition_index <= '0;
      bit_index        <= '0;
      want_temperature <= 1'b0;
      for (int i = 0; i < NUM_BYTES; i++) received_bytes[i] <= '0;
    end else if (cmd.accept) begin
      phase_timer      <= phase_timer_next;
      level_duration   <= level_duration_next;
      previous_level   <= previous_level_next;
      transition_index <= transition_index_next;
      bit_index        <= bit_index_next;
      want_temperature <= want_temperature_next;
      for (int i = 0; i < NUM_BYTES; i++) received_bytes[i] <= received_bytes_next[i];
    end
  end

  // Result register; held while the receiver stalls.
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      drive_enable <= en_now;
      drive_level  <= lvl_now;
      busy_res     <= cmd.busy;
      done_res     <= done_now;
      checksum_ok  <= ok_now;
      reading      <= reading_now;
    end
  end

endmodule

### rtl/humidity_sensor_wire_reader_unit.sv
`timescale 1ns / 1ps
// Top level of the single-wire humidity/temperature sensor reader.
// Instantiates hswr_ctrl and hswr_datapath; uses hswr_pkg and the channel interfaces.
//
// Usage:
//   in_ch carries one request per microsecond tick: start_req, choose_temperature
//   and the sampled wire_level. out_ch returns exactly one result per request:
//   the wire drive (drive_enable, drive_level), busy_res, and on the final tick
//   of a read done_res, checksum_ok and the chosen reading byte.
//   A start request drives the wire high, low, high for the configured counts,
//   then releases it and decodes 40 bits from the pulse widths.
//   The configuration port (cfg_we, cfg_index, cfg_data) sets the three drive
//   lengths and the one-bit threshold; write it only while no read is running.
// Timing:
//   One request is taken every cycle while the output does not stall; its result
//   appears in the result register in the cycle after acceptance. The rate is
//   set by the combinational phase and state update in the controller and datapath.
// Reset:
//   rst (synchronous) returns the phase to idle, clears the timing state and
//   reloads the default configuration.
// Stall:
//   While a result waits and out_ch.ready is low, it is held and in_ch.ready drops,
//   so no tick is lost; the next request is taken in the cycle the result leaves.
module humidity_sensor_wire_reader_unit (
  input  logic                            clk,
  input  logic                            rst,
  hswr_in_if.sink                         in_ch,
  hswr_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [hswr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [hswr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import hswr_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    in_ready;
  logic    out_valid;
  logic    drive_enable, drive_level, busy_res, done_res, checksum_ok;
  logic [BYTE_W-1:0] reading;

  // Phase controller
  hswr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ready),
    .start_req (in_ch.start_req),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd),
    .status    (status)
  );

  // Timing and decoding datapath
  hswr_datapath u_datapath (
    .clk                (clk),
    .rst                (rst),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_data           (cfg_data),
    .choose_temperature (in_ch.choose_temperature),
    .wire_level         (in_ch.wire_level),
    .cmd                (cmd),
    .status             (status),
    .drive_enable       (drive_enable),
    .drive_level        (drive_level),
    .busy_res           (busy_res),
    .done_res           (done_res),
    .checksum_ok        (checksum_ok),
    .reading            (reading)
  );

  // Channel connections
  assign in_ch.ready         = in_ready;
  assign out_ch.valid        = out_valid;
  assign out_ch.drive_enable = drive_enable;
  assign out_ch.drive_level  = drive_level;
  assign out_ch.busy_res     = busy_res;
  assign out_ch.done_res     = done_res;
  assign out_ch.checksum_ok  = checksum_ok;
  assign out_ch.reading      = reading;

endmodule

### rtl/hswr_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the sensor wire reader, bound to the top level.
// Depends only on the top level's channel signals.
module hswr_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic       drive_enable,
  input logic       drive_level,
  input logic       busy_res,
  input logic       done_res,
  input logic       checksum_ok,
  input logic [7:0] reading
);

  // A stalled result stays offered.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // The input side is never blocked while the result register is empty.
  assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A driven high level only appears while the wire is driven.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_level |-> drive_enable)
    else $error("drive level without drive enable");

  // A completed read ends the transaction and releases the wire.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && done_res |-> !busy_res && !drive_enable)
    else $error("done while still busy or driving");

  // The reading is zero unless the read completed with a good checksum.
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !(done_res && checksum_ok) |-> reading == 8'd0 && (done_res || !checksum_ok))
    else $error("reading or checksum flag outside a good completion");

endmodule

bind humidity_sensor_wire_reader_unit hswr_checker u_hswr_checker (
  .clk          (clk),
  .rst          (rst),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .drive_enable (out_ch.drive_enable),
  .drive_level  (out_ch.drive_level),
  .busy_res     (out_ch.busy_res),
  .done_res     (out_ch.done_res),
  .checksum_ok  (out_ch.checksum_ok),
  .reading      (out_ch.reading)
);
